FILE: rtl/core/fat32nc_pkg.sv
// ----------------------------------------------------------------------------
// fat32nc_pkg
// Shared types, codes and the FAT entry decode for the cached next-cluster
// lookup.
// ----------------------------------------------------------------------------
package fat32nc_pkg;

    // field widths; cluster and word widths are fixed by the FAT32 entry format
    localparam int unsigned CLUSTER_W = 28;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned SECTOR_W  = 32;
    localparam int unsigned STATUS_W  = 2;

    // entry decode constants
    localparam logic [WORD_W-1:0]    ENTRY_MASK   = 32'h0FFF_FFFF;
    localparam logic [CLUSTER_W-1:0] END_OF_CHAIN = 28'hFFF_FFF8;
    localparam logic [CLUSTER_W-1:0] BAD_CLUSTER  = 28'hFFF_FFF7;

    // item kinds
    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_FILL   = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_ANSWER = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FETCH  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

    // input beat
    typedef struct packed {
        logic                 kind;
        logic [CLUSTER_W-1:0] cluster;
        logic [WORD_W-1:0]    fill_word;
    } t_in_item;

    // result beat
    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic [CLUSTER_W-1:0] next_cluster;
        logic [SECTOR_W-1:0]  fetch_sector;
        logic                 cache_hit;
    } t_result;

    // mask to 28 bits, end of chain and bad cluster read as zero
    function automatic logic [CLUSTER_W-1:0] decode_entry(input logic [WORD_W-1:0] word);
        logic [CLUSTER_W-1:0] v;
        v = CLUSTER_W'(word & ENTRY_MASK);
        if (v >= END_OF_CHAIN || v == BAD_CLUSTER) begin
            return '0;
        end
        return v;
    endfunction

endpackage

FILE: rtl/core/fat32nc_ram.sv
// ----------------------------------------------------------------------------
// fat32nc_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module fat32nc_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 512
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/fat32nc_tags.sv
// ----------------------------------------------------------------------------
// fat32nc_tags
// Sector tags and valid bits of the fully associative cache, with a
// parallel match that gives the lowest matching slot.
// ----------------------------------------------------------------------------
module fat32nc_tags #(
    parameter int unsigned CACHE_ENTRIES = 4
) (
    input  logic                                                      i_clk,
    input  logic                                                      i_rst_n,
    input  logic [fat32nc_pkg::SECTOR_W-1:0]                          i_sector,
    input  logic                                                      i_clear_en,
    input  logic                                                      i_set_en,
    input  logic [(CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1)-1:0] i_slot,
    input  logic [fat32nc_pkg::SECTOR_W-1:0]                          i_set_sector,
    output logic                                                      o_hit,
    output logic [(CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1)-1:0] o_hit_slot
);

    localparam int unsigned SLOT_W = CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1;

    logic [CACHE_ENTRIES-1:0]          r_valid;
    logic [fat32nc_pkg::SECTOR_W-1:0]  r_tag [CACHE_ENTRIES];

    // valid bits, cleared by reset or by a clear, set by a set; a clear wins over a set
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_clear_en) begin
            r_valid[i_slot] <= 1'b0;
        end else if (i_set_en) begin
            r_valid[i_slot] <= 1'b1;
        end
    end

    // tags, written when a slot completes its fill
    always_ff @(posedge i_clk) begin
        if (i_set_en) begin
            r_tag[i_slot] <= i_set_sector;
        end
    end

    // parallel compare, lowest slot wins
    always_comb begin
        o_hit      = 1'b0;
        o_hit_slot = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && r_tag[i] == i_sector) begin
                o_hit      = 1'b1;
                o_hit_slot = SLOT_W'(i);
            end
        end
    end

endmodule

FILE: rtl/core/fat32_next_cluster_cached.sv
// ----------------------------------------------------------------------------
// fat32_next_cluster_cached
// FAT32 next-cluster lookup through a small fully associative sector cache
// held in one synchronous RAM, with round-robin refill from disk words.
// ----------------------------------------------------------------------------
//  channel   signals                         direction  transfer
//  item      start, busy, i_item             in         start && !busy
//  result    o_done, o_result                out        o_done, one cycle
//  config    i_cfg_valid, o_cfg_ready,       in         valid && ready
//            i_cfg_data
//
//  A hit lookup passes tag match, RAM read and result register; a miss
//  result is registered from the tag match, a reject result from the
//  beat. Each fill word is written to the store as it is taken, and the
//  last one registers its result at once. Reset is synchronous, active
//  low, and empties the cache at once through the valid bits. The result
//  side has no back pressure; busy holds only while a lookup is in flight.
//  SECTOR_WORDS must be a power of two.
// ----------------------------------------------------------------------------
module fat32_next_cluster_cached #(
    parameter int unsigned CACHE_ENTRIES = 4,
    parameter int unsigned SECTOR_WORDS  = 128
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  fat32nc_pkg::t_in_item            i_item,
    output logic                             o_done,
    output fat32nc_pkg::t_result             o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [fat32nc_pkg::SECTOR_W-1:0] i_cfg_data
);

    localparam int unsigned SLOT_W  = CACHE_ENTRIES > 1 ? $clog2(CACHE_ENTRIES) : 1;
    localparam int unsigned POS_W   = $clog2(SECTOR_WORDS);
    localparam int unsigned DEPTH   = CACHE_ENTRIES * SECTOR_WORDS;
    localparam int unsigned RAM_AW  = DEPTH > 1 ? $clog2(DEPTH) : 1;
    localparam int unsigned CL_W    = fat32nc_pkg::CLUSTER_W;
    localparam int unsigned SEC_W   = fat32nc_pkg::SECTOR_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_READ
    } t_state;

    // control registers
    t_state              r_state, n_state;
    logic                r_done, n_done;
    logic                r_fill_pending, n_fill_pending;
    logic [SLOT_W-1:0]   r_victim, n_victim;
    logic [POS_W-1:0]    r_fill_count, n_fill_count;
    logic [SEC_W-1:0]    r_fat_start;

    // payload registers
    logic [CL_W-1:0]             r_cluster, n_cluster;
    fat32nc_pkg::t_result        r_result, n_result;
    logic [SEC_W-1:0]            r_pending_sector, n_pending_sector;
    logic [POS_W-1:0]            r_pending_entry, n_pending_entry;
    logic [CL_W-1:0]             r_pending_answer, n_pending_answer;

    logic                        accept;
    logic [SEC_W-1:0]            look_sector;
    logic [POS_W-1:0]            look_entry;
    logic                        tag_hit;
    logic [SLOT_W-1:0]           tag_slot;
    logic                        tag_clear;
    logic                        tag_set;
    logic                        ram_we;
    logic [RAM_AW-1:0]           ram_waddr;
    logic [RAM_AW-1:0]           ram_raddr;
    logic [fat32nc_pkg::WORD_W-1:0] ram_rdata;
    logic [CL_W-1:0]             fill_decoded;
    logic [CL_W-1:0]             fill_answer;
    logic                        fill_last;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_result;

    // sector and entry of the lookup in flight
    assign look_sector = r_fat_start + SEC_W'(r_cluster >> POS_W);
    assign look_entry  = r_cluster[POS_W-1:0];

    // fill word decode and end of sector
    assign fill_decoded = fat32nc_pkg::decode_entry(i_item.fill_word);
    assign fill_answer  = (r_fill_count == r_pending_entry) ? fill_decoded : r_pending_answer;
    assign fill_last    = (r_fill_count == POS_W'(SECTOR_WORDS - 1));

    // store addresses: slot row, then word within the sector
    assign ram_waddr = (RAM_AW'(r_victim) << POS_W) | RAM_AW'(r_fill_count);
    assign ram_raddr = (RAM_AW'(tag_slot) << POS_W) | RAM_AW'(look_entry);

    fat32nc_tags #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_tags (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_sector     (look_sector),
        .i_clear_en   (tag_clear),
        .i_set_en     (tag_set),
        .i_slot       (r_victim),
        .i_set_sector (r_pending_sector),
        .o_hit        (tag_hit),
        .o_hit_slot   (tag_slot)
    );

    fat32nc_ram #(
        .WIDTH (fat32nc_pkg::WORD_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_item.fill_word),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next-state logic
    always_comb begin
        n_state          = r_state;
        n_done           = 1'b0;
        n_fill_pending   = r_fill_pending;
        n_victim         = r_victim;
        n_fill_count     = r_fill_count;
        n_cluster        = r_cluster;
        n_result         = r_result;
        n_pending_sector = r_pending_sector;
        n_pending_entry  = r_pending_entry;
        n_pending_answer = r_pending_answer;
        tag_clear        = 1'b0;
        tag_set          = 1'b0;
        ram_we           = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept && i_item.kind == fat32nc_pkg::KIND_LOOKUP) begin
                    if (r_fill_pending) begin
                        // lookup while a fill is open is turned away
                        n_done                = 1'b1;
                        n_result.status       = fat32nc_pkg::ST_REJECT;
                        n_result.next_cluster = '0;
                        n_result.fetch_sector = '0;
                        n_result.cache_hit    = 1'b0;
                    end else begin
                        n_cluster = i_item.cluster;
                        n_state   = S_LOOK;
                    end
                end else if (accept && r_fill_pending) begin
                    // fill beat goes straight into the victim row
                    ram_we = 1'b1;
                    if (r_fill_count == r_pending_entry) begin
                        n_pending_answer = fill_decoded;
                    end
                    if (fill_last) begin
                        tag_set        = 1'b1;
                        n_fill_pending = 1'b0;
                        n_fill_count   = '0;
                        n_victim       = (r_victim == SLOT_W'(CACHE_ENTRIES - 1)) ?
                                         '0 : r_victim + 1'b1;
                        n_done                = 1'b1;
                        n_result.status       = fat32nc_pkg::ST_ANSWER;
                        n_result.next_cluster = fill_answer;
                        n_result.fetch_sector = '0;
                        n_result.cache_hit    = 1'b0;
                    end else begin
                        n_fill_count = r_fill_count + 1'b1;
                    end
                end
            end
            S_LOOK: begin
                if (tag_hit) begin
                    // ram_raddr addresses the hit row this cycle
                    n_state = S_READ;
                end else begin
                    // miss: drop the victim and request the sector
                    tag_clear             = 1'b1;
                    n_fill_pending        = 1'b1;
                    n_pending_sector      = look_sector;
                    n_pending_entry       = look_entry;
                    n_fill_count          = '0;
                    n_pending_answer      = '0;
                    n_done                = 1'b1;
                    n_result.status       = fat32nc_pkg::ST_FETCH;
                    n_result.next_cluster = '0;
                    n_result.fetch_sector = look_sector;
                    n_result.cache_hit    = 1'b0;
                    n_state               = S_IDLE;
                end
            end
            S_READ: begin
                n_done                = 1'b1;
                n_result.status       = fat32nc_pkg::ST_ANSWER;
                n_result.next_cluster = fat32nc_pkg::decode_entry(ram_rdata);
                n_result.fetch_sector = '0;
                n_result.cache_hit    = 1'b1;
                n_state               = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_done         <= 1'b0;
            r_fill_pending <= 1'b0;
            r_victim       <= '0;
            r_fill_count   <= '0;
            r_fat_start    <= '0;
        end else begin
            r_state        <= n_state;
            r_done         <= n_done;
            r_fill_pending <= n_fill_pending;
            r_victim       <= n_victim;
            r_fill_count   <= n_fill_count;
            if (i_cfg_valid && o_cfg_ready) begin
                r_fat_start <= i_cfg_data;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cluster        <= n_cluster;
        r_result         <= n_result;
        r_pending_sector <= n_pending_sector;
        r_pending_entry  <= n_pending_entry;
        r_pending_answer <= n_pending_answer;
    end

    // a reject only goes out while a fill is open
    a_reject_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_result.status == fat32nc_pkg::ST_REJECT |-> r_fill_pending)
        else $error("reject result without an open fill");

    // fill position only moves during an open fill
    a_count_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_fill_pending |-> r_fill_count == '0)
        else $error("fill count nonzero with no open fill");

    // a store read always follows a tag hit
    a_read_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_LOOK && tag_hit |=> r_state == S_READ)
        else $error("tag hit did not start a store read");

    // a hit result is registered from the store read
    a_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_READ |=> o_done && o_result.cache_hit)
        else $error("store read did not give a hit result");

endmodule
